@@ design/dlr_pkg.sv @@
package dlr_pkg;

  localparam int SCREEN_BITS = 13;
  localparam int COLOR_BITS  = 4;
  localparam int ORIGIN_BITS = 11;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [ORIGIN_BITS-1:0] ORIGIN_X_RST = 11'd600;
  localparam logic [ORIGIN_BITS-1:0] ORIGIN_Y_RST = 11'd500;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ORIGIN_X = 1'b0,
    CFG_ORIGIN_Y = 1'b1
  } dlr_cfg_idx_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } dlr_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_ACTIVE
  } dlr_state_t;

endpackage

@@ design/dlr_if.sv @@
interface dlr_in_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [3:0]                   line_color;

  modport source (output valid, req_type, x_start, y_start, x_end, y_end, line_color,
                  input ready);
  modport sink (input valid, req_type, x_start, y_start, x_end, y_end, line_color,
                output ready);
endinterface

interface dlr_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] screen_x;
  logic signed [12:0] screen_y;
  logic [3:0]         pixel_color;
  logic               last_pixel;

  modport source (output valid, screen_x, screen_y, pixel_color, last_pixel,
                  input ready);
  modport sink (input valid, screen_x, screen_y, pixel_color, last_pixel,
                output ready);
endinterface

@@ design/dda_line_rasterizer.sv @@
// DDA line rasterizer.
// in_ch: req_type 0 loads a line (two world endpoints and a color), req_type 1
// asks for the next pixel. out_ch: one pixel per accepted step while a line is
// active, with screen_x/screen_y rounded half up and last_pixel on the final one.
// Steps with no active line are taken and dropped.
// cfg_*: write origin_x (index 0) and origin_y (index 1) while the block is idle.
// Load: in_ch.ready drops while the line is set up: a setup state orders the
// endpoints, then a shared compare/subtract divider produces one slope bit per
// cycle (FRACTION_BITS+2 bits including the round bit), then the slope is
// stored.
// Step: the pixel shows on out_ch in the cycle after the item is taken; steps
// are taken every cycle while out_ch is not stalled.
// The output register is refilled in the cycle it is drained; when the receiver
// stalls, the pixel holds and in_ch.ready stays low until it is taken.
// Reset (rst_n low, synchronous) drops any line, empties the output register
// and restores origin_x = 600, origin_y = 500.
module dda_line_rasterizer
  import dlr_pkg::*;
#(
  parameter int COORD_BITS    = 12,
  parameter int FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  dlr_in_if.sink                  in_ch,
  dlr_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ORIGIN_BITS-1:0]  cfg_wdata
);

  localparam int D_W   = COORD_BITS + 1;
  localparam int ACC_W = COORD_BITS + FRACTION_BITS + 1;
  localparam int INC_W = FRACTION_BITS + 2;
  localparam int SUM_W = FRACTION_BITS + SCREEN_BITS;

  dlr_state_t state_r, state_nxt;

  logic [ORIGIN_BITS-1:0] origin_x_r, origin_y_r;

  // latched endpoints
  logic signed [COORD_BITS-1:0] xs_r, ys_r, xe_r, ye_r;
  logic [COLOR_BITS-1:0]        color_r;

  logic                         steep_r;
  logic                         neg_r;
  logic signed [COORD_BITS-1:0] major_r, limit_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic signed [INC_W-1:0]      inc_r;

  logic                          out_valid_r;
  logic signed [SCREEN_BITS-1:0] sx_r, sy_r;
  logic [COLOR_BITS-1:0]         pcolor_r;
  logic                          last_r;

  logic in_take, take_load, take_step, out_free, div_start, div_done;
  logic [FRACTION_BITS:0] div_q;

  // ---- setup datapath ----
  logic signed [D_W-1:0]        dx, dy, adx, ady, dmaj, dmin, amin;
  logic                         steep;
  logic signed [COORD_BITS-1:0] ms, me, ns, ne, ms2, me2, ns2, ne2;
  logic                         swap;

  always_comb begin
    dx    = D_W'(xe_r) - D_W'(xs_r);
    dy    = D_W'(ye_r) - D_W'(ys_r);
    adx   = dx[D_W-1] ? -dx : dx;
    ady   = dy[D_W-1] ? -dy : dy;
    steep = ady > adx;
    ms    = steep ? ys_r : xs_r;
    me    = steep ? ye_r : xe_r;
    ns    = steep ? xs_r : ys_r;
    ne    = steep ? xe_r : ye_r;
    swap  = ms > me;
    ms2   = swap ? me : ms;
    me2   = swap ? ms : me;
    ns2   = swap ? ne : ns;
    ne2   = swap ? ns : ne;
    dmaj  = D_W'(me2) - D_W'(ms2);
    dmin  = D_W'(ne2) - D_W'(ns2);
    amin  = dmin[D_W-1] ? -dmin : dmin;
  end

  dlr_div #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(amin[COORD_BITS-1:0]),
    .divisor (dmaj[COORD_BITS-1:0]),
    .done    (div_done),
    .quotient(div_q)
  );

  // ---- pixel datapath ----
  logic [SUM_W-1:0]             ox_fix, oy_fix, half, acc_s, vx, vy;
  logic [SCREEN_BITS-1:0]       major_s, ox_s, oy_s;
  logic [SCREEN_BITS-1:0]       px, py;
  logic                         last;

  always_comb begin
    ox_fix  = SUM_W'({origin_x_r, {FRACTION_BITS{1'b0}}});
    oy_fix  = SUM_W'({origin_y_r, {FRACTION_BITS{1'b0}}});
    half    = SUM_W'(1) << (FRACTION_BITS - 1);
    acc_s   = SUM_W'(acc_r);
    major_s = SCREEN_BITS'(major_r);
    ox_s    = SCREEN_BITS'(origin_x_r);
    oy_s    = SCREEN_BITS'(origin_y_r);
    vx      = acc_s + ox_fix + half;
    vy      = oy_fix - acc_s + half;
    if (steep_r) begin
      px = vx[SUM_W-1:FRACTION_BITS];
      py = oy_s - major_s;
    end else begin
      px = major_s + ox_s;
      py = vy[SUM_W-1:FRACTION_BITS];
    end
    last = major_r >= limit_r;
  end

  // ---- sequencer ----
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = ((state_r == ST_IDLE) || (state_r == ST_ACTIVE)) && out_free;
  assign in_take   = in_ch.valid && in_ch.ready;
  assign take_load = in_take && (in_ch.req_type == REQ_LOAD);
  assign take_step = in_take && (in_ch.req_type == REQ_STEP) && (state_r == ST_ACTIVE);

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (take_load) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        div_start = 1'b1;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) state_nxt = ST_ACTIVE;
      end
      ST_ACTIVE: begin
        if (take_load) begin
          state_nxt = ST_SETUP;
        end else if (take_step && last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= ORIGIN_X_RST;
      origin_y_r <= ORIGIN_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: origin_x_r <= cfg_wdata;
        CFG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_load) begin
      xs_r    <= in_ch.x_start;
      ys_r    <= in_ch.y_start;
      xe_r    <= in_ch.x_end;
      ye_r    <= in_ch.y_end;
      color_r <= in_ch.line_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steep_r <= 1'b0;
      neg_r   <= 1'b0;
      major_r <= '0;
      limit_r <= '0;
      acc_r   <= '0;
      inc_r   <= '0;
    end else if (state_r == ST_SETUP) begin
      steep_r <= steep;
      neg_r   <= dmin[D_W-1];
      major_r <= ms2;
      limit_r <= me2;
      acc_r   <= {{(ACC_W-FRACTION_BITS-COORD_BITS){ns2[COORD_BITS-1]}}, ns2,
                  {FRACTION_BITS{1'b0}}};
    end else if (state_r == ST_DIVIDE) begin
      if (div_done) begin
        inc_r <= neg_r ? -INC_W'(div_q) : INC_W'(div_q);
      end
    end else if (take_step && !last) begin
      major_r <= major_r + COORD_BITS'(1);
      acc_r   <= acc_r + ACC_W'(inc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_step) begin
      sx_r     <= px;
      sy_r     <= py;
      pcolor_r <= color_r;
      last_r   <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.screen_x    = sx_r;
  assign out_ch.screen_y    = sy_r;
  assign out_ch.pixel_color = pcolor_r;
  assign out_ch.last_pixel  = last_r;

endmodule

@@ design/dlr_div.sv @@
module dlr_div
  import dlr_pkg::*;
#(
  parameter int COORD_BITS    = 12,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [COORD_BITS-1:0]    dividend,
  input  logic [COORD_BITS-1:0]    divisor,
  output logic                     done,
  output logic [FRACTION_BITS:0]   quotient
);

  // one quotient bit per cycle: integer bit, FRACTION_BITS fraction bits, one round bit
  localparam int STEPS = FRACTION_BITS + 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [COORD_BITS:0]   rem_r, rem_nxt;
  logic [COORD_BITS-1:0] den_r;
  logic [STEPS-1:0]      q_r, q_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic                  zero_r;

  logic [COORD_BITS+1:0] diff;
  logic                  qbit;
  logic [COORD_BITS-1:0] rem_sel;

  // shared compare/subtract unit
  assign diff    = {1'b0, rem_r} - {2'b00, den_r};
  assign qbit    = ~diff[COORD_BITS+1];
  assign rem_sel = qbit ? diff[COORD_BITS-1:0] : rem_r[COORD_BITS-1:0];
  assign rem_nxt = {rem_sel, 1'b0};
  assign q_nxt   = {q_r[STEPS-2:0], qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, dividend};
      den_r  <= divisor;
      q_r    <= '0;
      zero_r <= (dividend == '0);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done     = done_r;
  // round half away from zero on the magnitude
  assign quotient = zero_r ? '0 : (q_r[STEPS-1:1] + {{FRACTION_BITS{1'b0}}, q_r[0]});

endmodule

@@ design/dlr_checker.sv @@
module dlr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_req_type,
  input logic out_valid,
  input logic out_ready,
  input logic signed [12:0] out_screen_x,
  input logic signed [12:0] out_screen_y
);

  logic in_take;
  assign in_take = in_valid && in_ready;

  // a load item keeps the input closed while the slope is worked out
  a_load_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && !in_req_type |=> !in_ready)
    else $error("input open right after a load item");

  // a new pixel only follows an accepted step item
  a_pixel_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_take && in_req_type))
    else $error("pixel without a step item");

  a_load_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && !in_req_type |=> !$rose(out_valid))
    else $error("load item produced a pixel");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_screen_x) && $stable(out_screen_y))
    else $error("stalled pixel changed");

endmodule

bind dda_line_rasterizer dlr_checker u_dlr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_screen_x(out_ch.screen_x),
  .out_screen_y(out_ch.screen_y)
);
